/* hw/rtl/fpp_pkg.sv */
// Shared types and constants for the framed packet parser.
// Used by fpp_in_stage, fpp_parser and the top level; no dependencies.
`default_nettype none

package fpp_pkg;

    localparam int BYTE_W      = 8;
    localparam int TDATA_OUT_W = 48;

    // Start-of-frame byte after reset
    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;

    // Result kinds carried on tuser
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // One buffered input byte handed from the input stage to the parser
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } fpp_in_item_t;

    // One result transaction
    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] byte_index;
        logic [BYTE_W-1:0] frame_address;
        logic [BYTE_W-1:0] frame_id;
        logic [BYTE_W-1:0] data_length;
        logic              check_ok;
    } fpp_result_t;

endpackage

`default_nettype wire

/* hw/rtl/fpp_in_stage.sv */
// Input register with skid slot for the framed packet parser.
// Depends on fpp_pkg; registers tready so the upstream side never sees the parser stall path.
`default_nettype none

module fpp_in_stage (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [fpp_pkg::BYTE_W-1:0]  in_data,
    output fpp_pkg::fpp_in_item_t            item,
    input  wire logic                        item_take
);

    logic                       main_valid_reg;
    logic                       main_valid_next;
    logic [fpp_pkg::BYTE_W-1:0] main_data_reg;
    logic [fpp_pkg::BYTE_W-1:0] main_data_next;
    logic                       skid_valid_reg;
    logic                       skid_valid_next;
    logic [fpp_pkg::BYTE_W-1:0] skid_data_reg;
    logic [fpp_pkg::BYTE_W-1:0] skid_data_next;
    logic                       accept;
    logic                       main_free;

    assign in_ready   = !skid_valid_reg;
    assign accept     = in_valid && in_ready;
    assign main_free  = !main_valid_reg || item_take;
    assign item.valid = main_valid_reg;
    assign item.data  = main_data_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (main_free)
        begin
            // drain the skid slot first to keep order
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = accept;
                main_data_next  = in_data;
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    // a full skid slot implies the main register is occupied
    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid slot filled while main register empty");

    // a byte taken while the main register is stalled lands in the skid slot
    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && main_valid_reg && !item_take) |=> skid_valid_reg)
        else $error("accepted byte lost during stall");

    // skid contents move into the main register once it frees up
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && item_take) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid slot did not drain");

endmodule

`default_nettype wire

/* hw/rtl/fpp_parser.sv */
// Frame parse state machine, running checks and result register.
// Depends on fpp_pkg; takes one byte from fpp_in_stage per cycle when the result slot allows.
`default_nettype none

module fpp_parser (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [fpp_pkg::BYTE_W-1:0]  cfg_wr_data,
    input  wire fpp_pkg::fpp_in_item_t       item,
    output logic                             item_take,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output fpp_pkg::fpp_result_t             res
);

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_ADDR = 3'd1,
        PH_ID   = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_SUM  = 3'd5,
        PH_ADD  = 3'd6
    } phase_t;

    phase_t                     phase_reg;
    phase_t                     phase_next;
    logic [fpp_pkg::BYTE_W-1:0] header_reg;
    logic [fpp_pkg::BYTE_W-1:0] addr_reg;
    logic [fpp_pkg::BYTE_W-1:0] addr_next;
    logic [fpp_pkg::BYTE_W-1:0] id_reg;
    logic [fpp_pkg::BYTE_W-1:0] id_next;
    logic [fpp_pkg::BYTE_W-1:0] len_reg;
    logic [fpp_pkg::BYTE_W-1:0] len_next;
    logic [fpp_pkg::BYTE_W-1:0] remain_reg;
    logic [fpp_pkg::BYTE_W-1:0] remain_next;
    logic [fpp_pkg::BYTE_W-1:0] sum_reg;
    logic [fpp_pkg::BYTE_W-1:0] sum_next;
    logic [fpp_pkg::BYTE_W-1:0] add_reg;
    logic [fpp_pkg::BYTE_W-1:0] add_next;
    logic [fpp_pkg::BYTE_W-1:0] rx_sum_reg;
    logic [fpp_pkg::BYTE_W-1:0] rx_sum_next;
    logic [fpp_pkg::BYTE_W-1:0] sum_acc;
    logic [fpp_pkg::BYTE_W-1:0] add_acc;
    logic [fpp_pkg::BYTE_W-1:0] b;
    logic                       emit;
    fpp_pkg::fpp_result_t       res_next;
    logic                       res_valid_reg;
    logic                       res_valid_next;
    fpp_pkg::fpp_result_t       res_reg;

    assign b         = item.data;
    assign item_take = item.valid && (!res_valid_reg || res_ready);
    assign sum_acc   = sum_reg + b;
    assign add_acc   = add_reg + sum_acc;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        addr_next   = addr_reg;
        id_next     = id_reg;
        len_next    = len_reg;
        remain_next = remain_reg;
        sum_next    = sum_reg;
        add_next    = add_reg;
        rx_sum_next = rx_sum_reg;
        emit        = 1'b0;
        res_next.kind          = fpp_pkg::KIND_PAYLOAD;
        res_next.payload_byte  = '0;
        res_next.byte_index    = '0;
        res_next.frame_address = addr_reg;
        res_next.frame_id      = id_reg;
        res_next.data_length   = len_reg;
        res_next.check_ok      = 1'b0;
        case (phase_reg)
            PH_ADDR:
            begin
                addr_next  = b;
                sum_next   = sum_acc;
                add_next   = add_acc;
                phase_next = PH_ID;
            end
            PH_ID:
            begin
                id_next    = b;
                sum_next   = sum_acc;
                add_next   = add_acc;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                len_next    = b;
                remain_next = b;
                sum_next    = sum_acc;
                add_next    = add_acc;
                // zero length: check bytes follow directly
                phase_next  = (b == '0) ? PH_SUM : PH_DATA;
            end
            PH_DATA:
            begin
                sum_next    = sum_acc;
                add_next    = add_acc;
                remain_next = remain_reg - 1'b1;
                if (remain_reg == 8'd1)
                begin
                    phase_next = PH_SUM;
                end
                emit                  = 1'b1;
                res_next.payload_byte = b;
                res_next.byte_index   = len_reg - remain_reg;
            end
            PH_SUM:
            begin
                rx_sum_next = b;
                phase_next  = PH_ADD;
            end
            PH_ADD:
            begin
                emit              = 1'b1;
                res_next.kind     = fpp_pkg::KIND_STATUS;
                res_next.check_ok = (sum_reg == rx_sum_reg) && (add_reg == b);
                phase_next  = PH_HUNT;
                addr_next   = '0;
                id_next     = '0;
                len_next    = '0;
                remain_next = '0;
                sum_next    = '0;
                add_next    = '0;
                rx_sum_next = '0;
            end
            default:
            begin
                // hunting: drop anything but the header byte
                addr_next   = '0;
                id_next     = '0;
                len_next    = '0;
                remain_next = '0;
                rx_sum_next = '0;
                if (b == header_reg)
                begin
                    sum_next   = b;
                    add_next   = b;
                    phase_next = PH_ADDR;
                end
                else
                begin
                    sum_next   = '0;
                    add_next   = '0;
                    phase_next = PH_HUNT;
                end
            end
        endcase
        res_valid_next = (res_valid_reg && !res_ready) || (item_take && emit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg    <= fpp_pkg::HEADER_RESET;
            phase_reg     <= PH_HUNT;
            addr_reg      <= '0;
            id_reg        <= '0;
            len_reg       <= '0;
            remain_reg    <= '0;
            sum_reg       <= '0;
            add_reg       <= '0;
            rx_sum_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                header_reg <= cfg_wr_data;
            end
            if (item_take)
            begin
                phase_reg  <= phase_next;
                addr_reg   <= addr_next;
                id_reg     <= id_next;
                len_reg    <= len_next;
                remain_reg <= remain_next;
                sum_reg    <= sum_next;
                add_reg    <= add_next;
                rx_sum_reg <= rx_sum_next;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take && emit)
        begin
            res_reg <= res_next;
        end
    end

    a_status_returns_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && phase_reg == PH_ADD) |=> (phase_reg == PH_HUNT && sum_reg == '0))
        else $error("parser did not return to hunting after status");

    a_data_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (remain_reg != '0))
        else $error("payload phase with no bytes left");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.kind == fpp_pkg::KIND_PAYLOAD)
            |-> (res_reg.byte_index < res_reg.data_length && !res_reg.check_ok))
        else $error("payload result index out of frame range");

    a_status_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.kind == fpp_pkg::KIND_STATUS)
            |-> (res_reg.payload_byte == '0 && res_reg.byte_index == '0))
        else $error("status result carries payload fields");

endmodule

`default_nettype wire

/* hw/rtl/framed_packet_parser_dual_sum_check.sv */
// Framed packet parser top level: input skid stage feeding the parse/check stage.
// Depends on fpp_pkg, fpp_in_stage and fpp_parser.
`default_nettype none

// Takes one received byte per transaction, hunts for the header byte (cfg_wr_data,
// 0xAA after reset), then reads address, id, length, payload and two check bytes.
// Every payload byte leaves as its own transaction (tuser 0) with its index; after
// the add check byte one status transaction (tuser 1) reports address, id, length
// and whether the sum and add checks both matched. Throughput is one byte per
// clock while the result register is free or being taken: the parse step (state
// update plus two chained 8-bit adds) sits between the input register and the
// result register, which holds any result a byte yields. Header bytes seen inside
// a frame are treated as frame content; downstream must discard payload of a
// frame whose status shows a failed check.
module framed_packet_parser_dual_sum_check (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [fpp_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
                                             // [7:0] payload_byte, [15:8] byte_index,
                                             // [23:16] frame_address, [31:24] frame_id,
                                             // [39:32] data_length, [40] check_ok, rest 0
    output logic             m_axis_tuser    // [0] kind
);

    fpp_pkg::fpp_in_item_t item;
    logic                  item_take;
    fpp_pkg::fpp_result_t  res;

    fpp_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .item      (item),
        .item_take (item_take)
    );

    fpp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .item_take   (item_take),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res         (res)
    );

    assign m_axis_tdata = {7'b0, res.check_ok, res.data_length, res.frame_id,
                           res.frame_address, res.byte_index, res.payload_byte};
    assign m_axis_tuser = res.kind;

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for framed_packet_parser_dual_sum_check.
// Drives byte streams with framed packets, predicts payload and status results.
// Depends on fpp_pkg and the parser RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_PRINTED = 50;

    typedef enum logic [2:0] {
        SEEK_HEADER,
        GET_ADDR,
        GET_ID,
        GET_LEN,
        GET_DATA,
        GET_SUM,
        GET_ADD
    } parse_step_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_SUM,
        FLAW_ADD,
        FLAW_BOTH
    } check_flaw_t;

    class frame_scoreboard;
        logic [7:0]  header;
        parse_step_t phase;
        logic [7:0]  addr;
        logic [7:0]  fid;
        logic [7:0]  len;
        logic [7:0]  remaining;
        logic [7:0]  sum_acc;
        logic [7:0]  add_acc;
        logic [7:0]  rx_sum;
        fpp_pkg::fpp_result_t expected_q[$];
        int          errors;

        function new();
            header = fpp_pkg::HEADER_RESET;
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            phase     = SEEK_HEADER;
            addr      = '0;
            fid       = '0;
            len       = '0;
            remaining = '0;
            sum_acc   = '0;
            add_acc   = '0;
            rx_sum    = '0;
        endfunction

        function void fold(logic [7:0] b);
            sum_acc = sum_acc + b;
            add_acc = add_acc + sum_acc;
        endfunction

        // Advance the frame state by one accepted byte and queue any result it causes
        function void note_byte(logic [7:0] b);
            fpp_pkg::fpp_result_t r;
            r = '0;
            r.frame_address = addr;
            r.frame_id      = fid;
            r.data_length   = len;
            case (phase)
                GET_ADDR:
                begin
                    addr = b;
                    fold(b);
                    phase = GET_ID;
                end
                GET_ID:
                begin
                    fid = b;
                    fold(b);
                    phase = GET_LEN;
                end
                GET_LEN:
                begin
                    len = b;
                    remaining = b;
                    fold(b);
                    phase = (b == 8'd0) ? GET_SUM : GET_DATA;
                end
                GET_DATA:
                begin
                    r.kind         = fpp_pkg::KIND_PAYLOAD;
                    r.payload_byte = b;
                    r.byte_index   = len - remaining;
                    fold(b);
                    remaining = remaining - 8'd1;
                    if (remaining == 8'd0)
                        phase = GET_SUM;
                    expected_q.push_back(r);
                end
                GET_SUM:
                begin
                    rx_sum = b;
                    phase = GET_ADD;
                end
                GET_ADD:
                begin
                    r.kind     = fpp_pkg::KIND_STATUS;
                    r.check_ok = (sum_acc == rx_sum) && (add_acc == b);
                    expected_q.push_back(r);
                    clear_frame();
                end
                default:
                begin
                    clear_frame();
                    if (b == header)
                    begin
                        fold(b);
                        phase = GET_ADDR;
                    end
                end
            endcase
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED)
                $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [47:0] data, logic kind);
            fpp_pkg::fpp_result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result tdata=%h tuser=%b", data, kind));
                return;
            end
            want = expected_q.pop_front();
            if (kind !== want.kind)
                report($sformatf("kind got %b expected %b", kind, want.kind));
            if (data[7:0] !== want.payload_byte)
                report($sformatf("payload_byte got %h expected %h",
                                 data[7:0], want.payload_byte));
            if (data[15:8] !== want.byte_index)
                report($sformatf("byte_index got %h expected %h",
                                 data[15:8], want.byte_index));
            if (data[23:16] !== want.frame_address)
                report($sformatf("frame_address got %h expected %h",
                                 data[23:16], want.frame_address));
            if (data[31:24] !== want.frame_id)
                report($sformatf("frame_id got %h expected %h",
                                 data[31:24], want.frame_id));
            if (data[39:32] !== want.data_length)
                report($sformatf("data_length got %h expected %h",
                                 data[39:32], want.data_length));
            if (data[40] !== want.check_ok)
                report($sformatf("check_ok got %b expected %b", data[40], want.check_ok));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;

    int          rx_stall_pct = 0;
    logic        rx_hold = 1'b0;
    int          quiet_cycles = 0;
    logic [7:0]  stim_q[$];
    int          frame_bytes;

    frame_scoreboard sb = new();

    framed_packet_parser_dual_sum_check dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    // Receiver: random stalls, or a full hold-off while rx_hold is set
    always @(posedge clk)
    begin
        if (rx_hold)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            sb.note_byte(s_axis_tdata);
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL framed_packet_parser_dual_sum_check");
            $finish;
        end
    end

    // Append one frame with correct checks unless a flaw is asked for
    task automatic add_frame(input logic [7:0] hdr, input logic [7:0] a_byte,
                             input logic [7:0] id_byte, input logic [7:0] body[$],
                             input check_flaw_t flaw);
        logic [7:0] s;
        logic [7:0] acc;
        logic [7:0] seq[$];
        seq = {hdr, a_byte, id_byte, 8'(body.size())};
        seq = {seq, body};
        s = '0;
        acc = '0;
        foreach (seq[k])
        begin
            s = s + seq[k];
            acc = acc + s;
        end
        if (flaw == FLAW_SUM || flaw == FLAW_BOTH)
            s = s + 8'($urandom_range(1, 255));
        if (flaw == FLAW_ADD || flaw == FLAW_BOTH)
            acc = acc + 8'($urandom_range(1, 255));
        stim_q = {stim_q, seq, s, acc};
        frame_bytes += seq.size() + 2;
    endtask

    // Mostly well-formed frames with random content; some noise, bad checks, cut frames
    task automatic build_frames(input logic [7:0] hdr, input int target, input bit with_max);
        logic [7:0]  body[$];
        logic [7:0]  noise;
        int          n;
        int          roll;
        check_flaw_t flaw;
        frame_bytes = 0;
        while (frame_bytes < target || with_max)
        begin
            if ($urandom_range(99) < 20)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    noise = 8'($urandom);
                    if (noise == hdr && $urandom_range(9) != 0)
                        noise = noise ^ 8'h01;
                    stim_q.push_back(noise);
                end
            end
            if (with_max)
                n = 255;
            else if ($urandom_range(24) == 0)
                n = $urandom_range(13, 60);
            else
                n = $urandom_range(0, 12);
            with_max = 1'b0;
            body = {};
            repeat (n)
                body.push_back(($urandom_range(9) == 0) ? hdr : 8'($urandom));
            roll = $urandom_range(99);
            flaw = (roll < 70) ? FLAW_NONE : (roll < 80) ? FLAW_SUM :
                   (roll < 90) ? FLAW_ADD : FLAW_BOTH;
            add_frame(hdr, 8'($urandom), 8'($urandom), body, flaw);
            if ($urandom_range(99) < 4)
                repeat ($urandom_range(1, 3))
                    void'(stim_q.pop_back());
        end
    endtask

    task automatic send_bytes(input int idle_pct);
        foreach (stim_q[i])
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= stim_q[i];
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b0;
        stim_q.delete();
    endtask

    task automatic hold_receiver(input int cycles);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge clk);
        rx_hold <= 1'b0;
    endtask

    // Wait for every expected result, then let the pipeline drain bytes without results
    task automatic settle();
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_header(input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.header = value;
    endtask

    task automatic run_phase(input logic [7:0] hdr, input int tx_pct, input int rx_pct,
                             input int target, input bit with_max, input bit pressure);
        write_header(hdr);
        rx_stall_pct <= rx_pct;
        build_frames(hdr, target, with_max);
        if (pressure)
        begin
            fork
                send_bytes(tx_pct);
                hold_receiver(HOLD_CYCLES);
            join
        end
        else
            send_bytes(tx_pct);
        settle();
    endtask

    initial
    begin
        logic [7:0] body[$];
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: dropped bytes while hunting, zero length, header inside a frame,
        // failed add check, failed sum check; header is still at its reset value
        stim_q = {8'h00, 8'hFF};
        body = {};
        add_frame(fpp_pkg::HEADER_RESET, 8'hFF, 8'h00, body, FLAW_NONE);
        body = {fpp_pkg::HEADER_RESET, 8'hFF};
        add_frame(fpp_pkg::HEADER_RESET, 8'h00, 8'hFF, body, FLAW_ADD);
        body = {8'h00};
        add_frame(fpp_pkg::HEADER_RESET, 8'h5A, 8'hA5, body, FLAW_SUM);
        send_bytes(0);
        settle();

        run_phase(8'h00, 0, 0, 55, 1'b0, 1'b0);
        run_phase(8'hFF, 58, 0, 55, 1'b0, 1'b0);
        run_phase(8'($urandom_range(1, 254)), 0, 58, 55, 1'b0, 1'b0);
        run_phase(8'h55, 26, 26, 55, 1'b1, 1'b0);
        run_phase(8'hAA, 0, 0, 55, 1'b0, 1'b1);

        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.expected_q.size()));
        if (sb.errors == 0)
            $display("PASS framed_packet_parser_dual_sum_check");
        else
            $display("FAIL framed_packet_parser_dual_sum_check");
        $finish;
    end

endmodule
